// ----- hw/rtl/bit_packed_field_extract_core_macros.svh -----
// assertion macros used by the checker of the field extract core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BIT_PACKED_FIELD_EXTRACT_CORE_MACROS_SVH
`define BIT_PACKED_FIELD_EXTRACT_CORE_MACROS_SVH

// same-cycle implication
`define BPFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bpfe_pkg.sv -----
// types and constants of the bit-packed field extract core
// no dependencies
package bpfe_pkg;

  localparam int unsigned BufWordsDefault = 1024;
  localparam int unsigned StartW          = 26;
  localparam int unsigned CfgAddrW        = 4;
  localparam int unsigned CfgDataW        = 32;

  localparam logic [15:0] BitOffsetReset   = 16'd0;
  localparam logic [15:0] RowBiasReset     = 16'd0;
  localparam logic [6:0]  FieldWidthReset  = 7'd1;
  localparam logic [10:0] BufferWordsReset = 11'd1024;
  localparam logic [6:0]  MaxFieldWidth    = 7'd64;

  typedef enum logic [0:0] {
    CmdLoad    = 1'b0,
    CmdExtract = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegBitOffset   = 2'd0,
    RegRowBias     = 2'd1,
    RegFieldWidth  = 2'd2,
    RegBufferWords = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  word_index;
    logic [63:0] word_data;
    logic [16:0] row_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] field_value;
    logic        out_of_range;
  } out_item_t;

endpackage

// ----- hw/rtl/bit_packed_field_extract_core.sv -----
// Bit-packed field extractor. Load items write 64-bit words into an on-chip word
// memory; extract items return the field of a row, read LSB-first from up to two
// adjacent words. One item is accepted per cycle unless stalled; an extract passes
// the address stage and the align and mask stage, a load gives no result. The rate
// is set by the word memory, which reads both words of a field in one access.
// There is no clearing pass after reset: words must be loaded before they are read.
// depends on bpfe_pkg and bpfe_word_store
module bit_packed_field_extract_core #(
  parameter int unsigned BufWords = bpfe_pkg::BufWordsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bpfe_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bpfe_pkg::out_item_t            out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpfe_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bpfe_pkg::CfgDataW-1:0]  pwdata,
  output logic [bpfe_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned AddrW = $clog2(BufWords);
  localparam int unsigned VwW   = ($clog2(BufWords + 1) > 11) ? $clog2(BufWords + 1) : 11;
  localparam int unsigned SW    = bpfe_pkg::StartW;
  localparam int unsigned WW    = SW - 6;

  // configuration registers
  logic [15:0] bit_offset_q;
  logic [15:0] row_bias_q;
  logic [6:0]  field_width_q;
  logic [10:0] buffer_words_q;
  logic        cfg_wr;
  bpfe_pkg::cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = bpfe_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_offset_q   <= bpfe_pkg::BitOffsetReset;
      row_bias_q     <= bpfe_pkg::RowBiasReset;
      field_width_q  <= bpfe_pkg::FieldWidthReset;
      buffer_words_q <= bpfe_pkg::BufferWordsReset;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        bpfe_pkg::RegBitOffset:   bit_offset_q   <= pwdata[15:0];
        bpfe_pkg::RegRowBias:     row_bias_q     <= pwdata[15:0];
        bpfe_pkg::RegFieldWidth:  field_width_q  <= pwdata[6:0];
        bpfe_pkg::RegBufferWords: buffer_words_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      bpfe_pkg::RegBitOffset:   prdata = 32'(bit_offset_q);
      bpfe_pkg::RegRowBias:     prdata = 32'(row_bias_q);
      bpfe_pkg::RegFieldWidth:  prdata = 32'(field_width_q);
      bpfe_pkg::RegBufferWords: prdata = 32'(buffer_words_q);
      default:                  prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_adv, in_acc, is_extract;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_extract = (in_item_i.cmd == bpfe_pkg::CmdExtract);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = is_extract;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // address stage
  logic [6:0]           width_eff;
  logic signed [17:0]   rel;
  logic signed [SW-1:0] prod;
  logic signed [SW-1:0] start;
  logic signed [SW:0]   fend;
  logic signed [SW:0]   limit;
  logic [VwW-1:0]       valid_words;
  logic signed [WW-1:0] w0;
  logic signed [WW:0]   w0_x, w1, vw_s;
  logic                 v0_d, v1_d, oor_d;

  assign width_eff   = (field_width_q > bpfe_pkg::MaxFieldWidth) ? bpfe_pkg::MaxFieldWidth
                                                                 : field_width_q;
  assign rel         = $signed({1'b0, in_item_i.row_index}) - $signed({2'b00, row_bias_q});
  assign prod        = rel * $signed({1'b0, width_eff});
  assign start       = prod + $signed(SW'(bit_offset_q));
  assign fend        = $signed({start[SW-1], start}) + $signed((SW + 1)'(width_eff));
  assign valid_words = (VwW'(buffer_words_q) < VwW'(BufWords)) ? VwW'(buffer_words_q)
                                                                : VwW'(BufWords);
  assign limit       = $signed((SW + 1)'({valid_words, 6'd0}));
  assign w0          = start[SW-1:6];
  assign w0_x        = {w0[WW-1], w0};
  assign w1          = w0_x + $signed((WW + 1)'(1));
  assign vw_s        = $signed((WW + 1)'(valid_words));
  assign v0_d        = !w0_x[WW] && (w0_x < vw_s);
  assign v1_d        = !w1[WW] && (w1 < vw_s);
  assign oor_d       = (width_eff != 7'd0) && (start[SW-1] || (fend > limit));

  logic [5:0] shamt_q;
  logic [6:0] width_q;
  logic       v0_q, v1_q, oor_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && is_extract) begin
      shamt_q <= start[5:0];
      width_q <= width_eff;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
      oor_q   <= oor_d;
    end
  end

  // word memory
  logic             wr_en;
  logic [63:0]      rd_data0, rd_data1;

  assign wr_en = in_acc && (in_item_i.cmd == bpfe_pkg::CmdLoad)
                 && (32'(in_item_i.word_index) < 32'(BufWords));

  bpfe_word_store #(
    .Depth(BufWords),
    .AddrW(AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrW'(in_item_i.word_index)),
    .wr_data_i (in_item_i.word_data),
    .rd_en_i   (in_acc && is_extract),
    .rd_addr0_i(w0[AddrW-1:0]),
    .rd_addr1_i(w1[AddrW-1:0]),
    .rd_data0_o(rd_data0),
    .rd_data1_o(rd_data1)
  );

  // align and mask stage
  logic [127:0] pair, shifted;
  logic [63:0]  mask;
  bpfe_pkg::out_item_t out_item_q, out_item_d;

  assign pair    = {(v1_q ? rd_data1 : 64'd0), (v0_q ? rd_data0 : 64'd0)};
  assign shifted = pair >> shamt_q;
  assign mask    = (width_q >= bpfe_pkg::MaxFieldWidth) ? {64{1'b1}}
                                                        : ((64'd1 << width_q[5:0]) - 64'd1);

  always_comb begin
    out_item_d.field_value  = shifted[63:0] & mask;
    out_item_d.out_of_range = oor_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/bpfe_word_store.sv -----
// packed word memory: one write port, two registered read ports
// no dependencies beyond its parameters
module bpfe_word_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [63:0]      wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr0_i,
  input  logic [AddrW-1:0] rd_addr1_i,
  output logic [63:0]      rd_data0_o,
  output logic [63:0]      rd_data1_o
);

  logic [63:0] mem_q [Depth];
  logic [63:0] rd_data0_q;
  logic [63:0] rd_data1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_q <= mem_q[rd_addr0_i];
      rd_data1_q <= mem_q[rd_addr1_i];
    end
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

// ----- hw/rtl/bpfe_checker.sv -----
// port-level checker for the field extract core, bound to the top level
// depends on bpfe_pkg and the assertion macro header
`include "bit_packed_field_extract_core_macros.svh"

module bpfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bpfe_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bpfe_pkg::out_item_t out_item_o
);

  // extract items accepted but not yet delivered
  logic [2:0] pend_q, pend_d;
  logic       ext_acc, res_acc;

  assign ext_acc = in_valid_i && !in_stall_o && (in_item_i.cmd == bpfe_pkg::CmdExtract);
  assign res_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (ext_acc && !res_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (res_acc && !ext_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BPFE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `BPFE_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o), "stalled result changed")
  `BPFE_ASSERT_IMP(a_no_phantom, out_valid_o, pend_q != 3'd0, "result without a pending extract")
  `BPFE_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= 3'd2, "more extracts in flight than stages")

endmodule

bind bit_packed_field_extract_core bpfe_checker u_bpfe_checker (.*);
